### rtl/assert_macros.svh
// Assertion macros shared by the feedback delay line modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FDL_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("feedback delay line assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FDL_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("feedback delay line assertion failed");

`endif

### rtl/fdl_pkg.sv
// Types, constants, microcode table and helpers of the feedback delay line.
package fdl_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int GAIN_W        = 17;
  localparam int FB_GAIN_W     = 16;
  localparam int FRAC_W        = 8;
  localparam int CFG_DATA_W    = 23;
  localparam int CFG_INDEX_W   = 2;
  localparam int ACC_W         = 35;
  localparam int SAT_W         = 19;
  localparam int DEPTH_DEFAULT = 32768;

  localparam logic [FB_GAIN_W-1:0] FB_CAP = 16'd64880;
  localparam logic [GAIN_W-1:0]    UNITY  = 17'd65536;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DELAY_Q8,
    CFG_FEEDBACK_GAIN,
    CFG_MIX_GAIN,
    CFG_FILTER_COEFF
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAC_W-1:0]    frac;
    logic [FB_GAIN_W-1:0] fb_gain;
    logic [GAIN_W-1:0]    mix;
    logic [GAIN_W-1:0]    coeff;
  } cfg_t;

  typedef enum logic [1:0] {MAC_NONE, MAC_LOAD, MAC_ADD} mac_op_t;
  typedef enum logic [1:0] {A_RDATA, A_X, A_DLY, A_TMP} a_sel_t;
  typedef enum logic [2:0] {B_FRAC_INV, B_FRAC, B_MIX_INV, B_MIX, B_FB, B_COEFF} b_sel_t;
  typedef enum logic [2:0] {MEM_NONE, MEM_READ_R0, MEM_READ_R1, MEM_WRITE, MEM_CLEAR} mem_op_t;
  typedef enum logic [2:0] {
    COND_NEXT, COND_JUMP, COND_WAIT_CLR, COND_WAIT_IN, COND_WAIT_OUT
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_CLEAR = 4'd0;
  localparam step_t STEP_IDLE  = 4'd1;
  localparam step_t STEP_RD0   = 4'd2;
  localparam step_t STEP_RD1   = 4'd3;
  localparam step_t STEP_BLEND = 4'd4;
  localparam step_t STEP_DRY   = 4'd5;
  localparam step_t STEP_WET   = 4'd6;
  localparam step_t STEP_EMIT  = 4'd7;
  localparam step_t STEP_DIFF  = 4'd8;
  localparam step_t STEP_FILT  = 4'd9;
  localparam step_t STEP_STATE = 4'd10;
  localparam step_t STEP_STORE = 4'd11;

  typedef struct packed {
    mac_op_t mac;
    a_sel_t  a;
    b_sel_t  b;
    mem_op_t mem;
    logic    take_in;
    logic    ld_dly;
    logic    ld_tmp;
    logic    ld_lp;
    logic    emit;
    logic    adv_wp;
    cond_t   cond;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic clr_last;
  } status_t;

  localparam ctrl_t CTRL_NOP = '{
    mac: MAC_NONE, a: A_RDATA, b: B_FRAC_INV, mem: MEM_NONE,
    take_in: 1'b0, ld_dly: 1'b0, ld_tmp: 1'b0, ld_lp: 1'b0,
    emit: 1'b0, adv_wp: 1'b0, cond: COND_NEXT, target: STEP_IDLE
  };

  // The per-sample program. Each step is one control word.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (s)
      STEP_CLEAR: begin
        w.mem  = MEM_CLEAR;
        w.cond = COND_WAIT_CLR;
      end
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_WAIT_IN;
      end
      STEP_RD0: begin
        w.mem = MEM_READ_R0;
      end
      STEP_RD1: begin
        w.mem = MEM_READ_R1;
        w.mac = MAC_LOAD;
        w.a   = A_RDATA;
        w.b   = B_FRAC_INV;
      end
      STEP_BLEND: begin
        w.mac = MAC_ADD;
        w.a   = A_RDATA;
        w.b   = B_FRAC;
      end
      STEP_DRY: begin
        w.ld_dly = 1'b1;
        w.mac    = MAC_LOAD;
        w.a      = A_X;
        w.b      = B_MIX_INV;
      end
      STEP_WET: begin
        w.mac = MAC_ADD;
        w.a   = A_DLY;
        w.b   = B_MIX;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.mac  = MAC_LOAD;
        w.a    = A_DLY;
        w.b    = B_FB;
        w.cond = COND_WAIT_OUT;
      end
      STEP_DIFF: begin
        w.ld_tmp = 1'b1;
      end
      STEP_FILT: begin
        w.mac = MAC_LOAD;
        w.a   = A_TMP;
        w.b   = B_COEFF;
      end
      STEP_STATE: begin
        w.ld_lp = 1'b1;
      end
      STEP_STORE: begin
        w.mem    = MEM_WRITE;
        w.adv_wp = 1'b1;
        w.cond   = COND_JUMP;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_JUMP;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end
    if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

### rtl/fdl_sample_if.sv
// Valid/ready sample channel with source and sink views.
interface fdl_sample_if
  import fdl_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/fdl_sequencer.sv
// Step counter and microcode table that drive the datapath.
`include "assert_macros.svh"

module fdl_sequencer
  import fdl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t stat,
  output ctrl_t   ctrl,
  output logic    fire
);

  step_t step;
  step_t step_next;

  assign ctrl = ucode(step);

  // A step waits until its condition is met; fire gates loads, not ring access.
  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:     fire = 1'b1;
      COND_JUMP:     fire = 1'b1;
      COND_WAIT_CLR: fire = stat.clr_last;
      COND_WAIT_IN:  fire = stat.in_valid;
      COND_WAIT_OUT: fire = !stat.out_busy;
      default:       fire = 1'b1;
    endcase
    if (!fire) begin
      step_next = step;
    end else if (ctrl.cond == COND_JUMP) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  `FDL_ASSERT_NEXT(a_store_then_idle, clk, rst, ctrl.mem == MEM_WRITE, step == STEP_IDLE)

endmodule

### rtl/fdl_datapath.sv
// Ring memory, shared multiply-accumulate unit and sample registers.
`include "assert_macros.svh"

module fdl_datapath
  import fdl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  ctrl_t         ctrl,
  input  logic          fire,
  output status_t       stat,
  input  cfg_t          cfg,
  input  logic [AW-1:0] delay_whole,
  fdl_sample_if.sink    sample_in,
  fdl_sample_if.source  sample_out
);

  logic signed [SAMPLE_W-1:0] ring [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;

  logic [AW-1:0] wp;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] r0;
  logic [AW-1:0] r1;
  logic [AW-1:0] r0_calc;
  logic [AW-1:0] r1_calc;
  logic [AW:0]   r0_wrap;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] dly;
  logic signed [SAMPLE_W:0]   tmp;
  logic signed [SAMPLE_W-1:0] lp;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_valid;
  logic signed [ACC_W-1:0]    acc;

  logic signed [GAIN_W-1:0] a_op;
  logic [GAIN_W-1:0]        b_op;
  logic signed [ACC_W-1:0]  prod;

  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;

  assign sample_in.ready   = ctrl.take_in;
  assign sample_out.valid  = out_valid;
  assign sample_out.sample = out_sample;

  assign stat.in_valid = sample_in.valid;
  assign stat.out_busy = out_valid && !sample_out.ready;
  assign stat.clr_last = (clr_addr == AW'(DEPTH - 1));

  // Read addresses for the newer and the older tap, wrapping around the ring.
  assign r0_wrap = {1'b0, wp} + (AW + 1)'(DEPTH) - {1'b0, delay_whole};
  assign r0_calc = (wp >= delay_whole) ? (wp - delay_whole) : r0_wrap[AW-1:0];
  assign r1_calc = (r0_calc == '0) ? AW'(DEPTH - 1) : (r0_calc - AW'(1));

  always_comb begin
    unique case (ctrl.a)
      A_RDATA: a_op = {rdata[SAMPLE_W-1], rdata};
      A_X:     a_op = {x[SAMPLE_W-1], x};
      A_DLY:   a_op = {dly[SAMPLE_W-1], dly};
      A_TMP:   a_op = tmp;
      default: a_op = tmp;
    endcase
    unique case (ctrl.b)
      B_FRAC_INV: b_op = GAIN_W'(9'd256 - {1'b0, cfg.frac});
      B_FRAC:     b_op = GAIN_W'(cfg.frac);
      B_MIX_INV:  b_op = UNITY - cfg.mix;
      B_MIX:      b_op = cfg.mix;
      B_FB:       b_op = GAIN_W'(cfg.fb_gain);
      B_COEFF:    b_op = cfg.coeff;
      default:    b_op = '0;
    endcase
  end

  assign prod = a_op * $signed({1'b0, b_op});

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wp;
    mem_raddr = r0;
    mem_wdata = sat16($signed({{3{x[SAMPLE_W-1]}}, x}) + $signed({{3{lp[SAMPLE_W-1]}}, lp}));
    unique case (ctrl.mem)
      MEM_NONE: begin
      end
      MEM_READ_R0: begin
        mem_re = 1'b1;
      end
      MEM_READ_R1: begin
        mem_re    = 1'b1;
        mem_raddr = r1;
      end
      MEM_WRITE: begin
        mem_we = 1'b1;
      end
      MEM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= ring[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      clr_addr  <= '0;
      lp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.mem == MEM_CLEAR) begin
        clr_addr <= stat.clr_last ? '0 : clr_addr + AW'(1);
      end
      if (fire && ctrl.adv_wp) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (fire && ctrl.ld_lp) begin
        lp <= sat16($signed(acc[ACC_W-1:16]) + $signed({{3{lp[SAMPLE_W-1]}}, lp}));
      end
      if (fire && ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (sample_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.take_in) begin
      x  <= sample_in.sample;
      r0 <= r0_calc;
      r1 <= r1_calc;
    end
    if (fire) begin
      unique case (ctrl.mac)
        MAC_NONE: begin
        end
        MAC_LOAD: acc <= prod;
        MAC_ADD:  acc <= acc + prod;
        default: begin
        end
      endcase
    end
    if (fire && ctrl.ld_dly) begin
      dly <= acc[23:8];
    end
    if (fire && ctrl.ld_tmp) begin
      tmp <= {acc[31], acc[31:16]} - {lp[SAMPLE_W-1], lp};
    end
    if (fire && ctrl.emit) begin
      out_sample <= sat16($signed(acc[ACC_W-1:16]));
    end
  end

  `FDL_ASSERT_IMPL(a_no_clobber, clk, rst, fire && ctrl.emit, !(out_valid && !sample_out.ready))
  `FDL_ASSERT_IMPL(a_read_range, clk, rst, mem_re, 32'(mem_raddr) < 32'(DEPTH))

endmodule

### rtl/feedback_delay_line_core.sv
// Feedback delay line: a delay effect with interpolated taps and damped feedback.
// Each accepted sample runs a microcode program over one shared 17x18
// multiply-accumulate unit and one ring memory port: two tap reads, the
// fractional blend, the dry/wet mix, the feedback gain, the lowpass update and
// the ring write; the next sample is taken only once the program is back at its
// idle step, and the result step waits while an earlier result is unread. After
// reset a clearing pass zeroes the ring one entry per cycle, all DEPTH entries
// (32768 by default), and no sample is accepted until it ends; configuration
// writes are taken at any time and should be made while the block is idle.
module feedback_delay_line_core
  import fdl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  fdl_sample_if.sink             sample_in,
  fdl_sample_if.source           sample_out
);

  localparam int AW = $clog2(DEPTH);

  cfg_t          cfg;
  logic [AW-1:0] delay_whole;
  ctrl_t         ctrl;
  status_t       stat;
  logic          fire;

  // Registers are stored already limited, so the datapath sees usable values.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_whole <= '0;
      cfg.frac    <= '0;
      cfg.fb_gain <= '0;
      cfg.mix     <= '0;
      cfg.coeff   <= UNITY;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DELAY_Q8: begin
          if (32'(cfg_data[CFG_DATA_W-1:FRAC_W]) >= 32'(DEPTH - 1)) begin
            delay_whole <= AW'(DEPTH - 1);
            cfg.frac    <= '0;
          end else begin
            delay_whole <= AW'(cfg_data[CFG_DATA_W-1:FRAC_W]);
            cfg.frac    <= cfg_data[FRAC_W-1:0];
          end
        end
        CFG_FEEDBACK_GAIN: begin
          cfg.fb_gain <= (cfg_data[FB_GAIN_W-1:0] > FB_CAP) ? FB_CAP : cfg_data[FB_GAIN_W-1:0];
        end
        CFG_MIX_GAIN: begin
          cfg.mix <= (cfg_data[GAIN_W-1:0] > UNITY) ? UNITY : cfg_data[GAIN_W-1:0];
        end
        CFG_FILTER_COEFF: begin
          cfg.coeff <= (cfg_data[GAIN_W-1:0] > UNITY) ? UNITY : cfg_data[GAIN_W-1:0];
        end
      endcase
    end
  end

  fdl_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .fire (fire)
  );

  fdl_datapath #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .fire        (fire),
    .stat        (stat),
    .cfg         (cfg),
    .delay_whole (delay_whole),
    .sample_in   (sample_in),
    .sample_out  (sample_out)
  );

endmodule
